// File: hw/rtl/camera_primary_ray_direction_defines.svh
// assertion macros for the camera primary ray direction block
// expects clk and arst_n in the scope of each use
`ifndef CAMERA_PRIMARY_RAY_DIRECTION_DEFINES_SVH
`define CAMERA_PRIMARY_RAY_DIRECTION_DEFINES_SVH

// same-cycle implication, muted during reset
`define CPRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, muted during reset
`define CPRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/cprd_pkg.sv
// shared types and constants of the camera primary ray direction block
// no dependencies
package cprd_pkg;

	localparam int COL_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int SCALAR_W   = 31;
	localparam int ENTRY_W    = 16;
	localparam int NORM_W     = 30;
	localparam int NORM_TOP   = 29;
	localparam int RAD_W      = 62;
	localparam int ROOT_W     = 31;
	localparam int FRAC_W     = 14;
	localparam int Q_W        = 15;
	localparam int NUM_W      = 45;
	localparam int DIR_W      = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_PITCH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROW0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROW1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROW2 = 3'd5;

	localparam logic [SCALAR_W-1:0]   HALF_WIDTH_RST  = 31'd16777216;
	localparam logic [SCALAR_W-1:0]   HALF_HEIGHT_RST = 31'd16777216;
	localparam logic [SCALAR_W-1:0]   PIXEL_PITCH_RST = 31'd131072;
	localparam logic [CFG_DATA_W-1:0] MATRIX_ROW0_RST = 48'd16384;
	localparam logic [CFG_DATA_W-1:0] MATRIX_ROW1_RST = 48'd1073741824;
	localparam logic [CFG_DATA_W-1:0] MATRIX_ROW2_RST = 48'd70368744177664;

	// image plane sits at z = -1, which is 2^25 in the doubled Q8.24 scale
	localparam int PLANE_Z_MAG = 33554432;

	typedef struct packed {
		logic [COL_W-1:0] pixel_col;
		logic [COL_W-1:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
		logic                    degenerate;
	} ray_t;

	// normalized magnitudes and signs riding beside the square root
	typedef struct packed {
		logic [2:0][NORM_W-1:0] mag;
		logic [2:0]             neg;
		logic                   degen;
	} norm_t;

	// quotients leaving the divider
	typedef struct packed {
		logic [2:0][Q_W-1:0] q;
		logic [2:0]          neg;
		logic                degen;
	} quot_t;

endpackage

// File: hw/rtl/camera_primary_ray_direction.sv
// pinhole camera primary ray direction: pixel in, unit direction out
// depends on cprd_pkg, cprd_sqrt, cprd_div and the assertion macro header
//
// usage
//   pixel channel: one request per pixel (pixel_col, pixel_row), valid/ready
//   ray channel: one request per pixel (dir_x, dir_y, dir_z in Q1.14, degenerate)
//   cfg channel: register index and data; always ready, write only while idle
// timing
//   a fully pipelined datapath: one pixel per cycle sustained while the
//   output queue has room; on its way to ray_valid a pixel passes the
//   31 stages of the bit-per-stage square root and the 15 divider stages
//   plus nine front stages (plane point, rotation, normalization, squares)
// reset
//   all pipeline valid bits and the output queue clear; registers take the
//   identity matrix, half sizes of 1.0 and a pitch of 2^-7
// stalls
//   results land in a two-entry output queue; the whole pipeline holds when
//   the queue is full, so a stalled receiver loses nothing and the pixel
//   side keeps going while one finished ray still waits
`include "camera_primary_ray_direction_defines.svh"

module camera_primary_ray_direction #(
	parameter int COORD_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  cprd_pkg::pixel_t               pixel,
	output logic                           ray_valid,
	input  logic                           ray_ready,
	output cprd_pkg::ray_t                 ray,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cprd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cprd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cprd_pkg::*;

	// coordinate bits actually used, capped by the port width
	localparam int CB     = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
	localparam int PROD_W = CB + 32;      // (2c+1) * pitch
	localparam int VW     = CB + 33;      // signed plane point, always below 2^45
	localparam int MP_W   = VW + 16;      // matrix entry times plane value
	localparam int DW     = VW + 18;      // rotated component, signed
	localparam int MW     = VW + 17;      // its magnitude
	localparam int NG     = (MW + 7) / 8; // byte groups for the leading-one search
	localparam int GW     = $clog2(NG);
	localparam int PW     = GW + 3;
	localparam int SH_W   = MW + NORM_TOP;

	localparam logic signed [VW-1:0] PLANE_Z = VW'(-PLANE_Z_MAG);

	// configuration registers
	logic [SCALAR_W-1:0]   half_width_q;
	logic [SCALAR_W-1:0]   half_height_q;
	logic [SCALAR_W-1:0]   pixel_pitch_q;
	logic [CFG_DATA_W-1:0] mrow_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= HALF_WIDTH_RST;
			half_height_q <= HALF_HEIGHT_RST;
			pixel_pitch_q <= PIXEL_PITCH_RST;
			mrow_q[0]     <= MATRIX_ROW0_RST;
			mrow_q[1]     <= MATRIX_ROW1_RST;
			mrow_q[2]     <= MATRIX_ROW2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HALF_WIDTH:  half_width_q  <= cfg_data[SCALAR_W-1:0];
				CFG_HALF_HEIGHT: half_height_q <= cfg_data[SCALAR_W-1:0];
				CFG_PIXEL_PITCH: pixel_pitch_q <= cfg_data[SCALAR_W-1:0];
				CFG_MATRIX_ROW0: mrow_q[0]     <= cfg_data;
				CFG_MATRIX_ROW1: mrow_q[1]     <= cfg_data;
				CFG_MATRIX_ROW2: mrow_q[2]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advance: held only while the output queue is full
	logic [1:0] fifo_cnt_q;
	logic       adv;

	assign adv         = (fifo_cnt_q != 2'd2);
	assign pixel_ready = adv;

	// front-end valid bits, stages 1 to 9
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (adv) begin
			v_s1 <= pixel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 1: odd pixel offsets (2c+1) times the pitch
	logic [CB:0]        odd_col, odd_row;
	logic [PROD_W-1:0]  px_s1, py_s1;

	assign odd_col = {pixel.pixel_col[CB-1:0], 1'b1};
	assign odd_row = {pixel.pixel_row[CB-1:0], 1'b1};

	// stage 2: plane point in units of 2^-25
	logic signed [VW-1:0] v_s2_vec [3];

	// stage 3: nine matrix products
	logic signed [MP_W-1:0] prod_s3 [3][3];
	logic signed [ENTRY_W-1:0] m_ent [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m_ent[i][j] = $signed(mrow_q[i][ENTRY_W*j +: ENTRY_W]);
			end
		end
	end

	// stage 4: rotated components
	logic signed [DW-1:0] d_s4 [3];

	// stage 5: sign and magnitude
	logic [MW-1:0] mag_s5 [3];
	logic [2:0]    neg_s5;

	// stage 6: position of the leading one over all three magnitudes
	logic [MW-1:0]     mag_s6 [3];
	logic [2:0]        neg_s6;
	logic [PW-1:0]     lead_s6;
	logic              dgn_s6;
	logic [MW-1:0]     or_all;
	logic [NG*8-1:0]   or_pad;
	logic [GW-1:0]     top_grp;
	logic [2:0]        top_bit;
	logic [7:0]        grp_bits;

	always_comb begin
		or_all  = mag_s5[0] | mag_s5[1] | mag_s5[2];
		or_pad  = (NG*8)'(or_all);
		top_grp = '0;
		for (int g = 0; g < NG; g++) begin
			if (|or_pad[8*g +: 8]) top_grp = GW'(g);
		end
		grp_bits = or_pad[8*top_grp +: 8];
		top_bit  = '0;
		for (int b = 0; b < 8; b++) begin
			if (grp_bits[b]) top_bit = 3'(b);
		end
	end

	// stage 7: common shift that puts the leading one at bit 29
	norm_t            nrm_s7;
	logic [SH_W-1:0]  shifted [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shifted[i] = {mag_s6[i], {NORM_TOP{1'b0}}} >> lead_s6;
		end
	end

	// stage 8: squares, stage 9: their sum
	logic [2*NORM_W-1:0] sq_s8 [3];
	norm_t               nrm_s8;
	logic [RAD_W-1:0]    sum_s9;
	norm_t               nrm_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= PROD_W'(odd_col) * PROD_W'(pixel_pitch_q);
			py_s1 <= PROD_W'(odd_row) * PROD_W'(pixel_pitch_q);

			v_s2_vec[0] <= $signed({{(VW-SCALAR_W-1){1'b0}}, half_width_q, 1'b0})
				- $signed({1'b0, px_s1});
			v_s2_vec[1] <= $signed({{(VW-SCALAR_W-1){1'b0}}, half_height_q, 1'b0})
				- $signed({1'b0, py_s1});
			v_s2_vec[2] <= PLANE_Z;

			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s3[i][j] <= MP_W'(m_ent[i][j]) * MP_W'(v_s2_vec[j]);
				end
			end

			for (int i = 0; i < 3; i++) begin
				d_s4[i] <= DW'(prod_s3[i][0]) + DW'(prod_s3[i][1]) + DW'(prod_s3[i][2]);
			end

			for (int i = 0; i < 3; i++) begin
				neg_s5[i] <= d_s4[i][DW-1];
				mag_s5[i] <= d_s4[i][DW-1] ? MW'(-d_s4[i]) : MW'(d_s4[i]);
			end

			mag_s6  <= mag_s5;
			neg_s6  <= neg_s5;
			lead_s6 <= {top_grp, top_bit};
			dgn_s6  <= (or_all == '0);

			for (int i = 0; i < 3; i++) begin
				nrm_s7.mag[i] <= shifted[i][NORM_W-1:0];
			end
			nrm_s7.neg   <= neg_s6;
			nrm_s7.degen <= dgn_s6;

			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= (2*NORM_W)'(nrm_s7.mag[i]) * (2*NORM_W)'(nrm_s7.mag[i]);
			end
			nrm_s8 <= nrm_s7;

			sum_s9 <= RAD_W'(sq_s8[0]) + RAD_W'(sq_s8[1]) + RAD_W'(sq_s8[2]);
			nrm_s9 <= nrm_s8;
		end
	end

	// vector length
	logic              v_len;
	logic [ROOT_W-1:0] len;
	norm_t             nrm_len;

	cprd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s9),
		.radicand (sum_s9),
		.in_side  (nrm_s9),
		.out_valid(v_len),
		.root     (len),
		.out_side (nrm_len)
	);

	// rounded quotients
	logic  v_div;
	quot_t quot;

	cprd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_len),
		.len      (len),
		.in_side  (nrm_len),
		.out_valid(v_div),
		.quot     (quot)
	);

	// signs back on, zero vector forced to zero direction
	ray_t            ray_new;
	logic [DIR_W-1:0] dir_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (quot.degen) begin
				dir_c[i] = '0;
			end else if (quot.neg[i]) begin
				dir_c[i] = DIR_W'(-$signed({1'b0, quot.q[i]}));
			end else begin
				dir_c[i] = DIR_W'({1'b0, quot.q[i]});
			end
		end
		ray_new.dir_x      = dir_c[0];
		ray_new.dir_y      = dir_c[1];
		ray_new.dir_z      = dir_c[2];
		ray_new.degenerate = quot.degen;
	end

	// two-entry output queue, head is the ray port
	ray_t ent0_q, ent1_q;
	logic push, pop;

	assign push = adv && v_div;
	assign pop  = ray_valid && ray_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 2'd1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (fifo_cnt_q == 2'd0) ent0_q <= ray_new;
				else ent1_q <= ray_new;
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				if (fifo_cnt_q == 2'd1) begin
					ent0_q <= ray_new;
				end else begin
					ent0_q <= ent1_q;
					ent1_q <= ray_new;
				end
			end
			default: ;
		endcase
	end

	assign ray_valid = (fifo_cnt_q != 2'd0);
	assign ray       = ent0_q;

	// checks
	`CPRD_ASSERT_NOW(a_degen_zero, ray_valid && ray.degenerate, ray.dir_x == '0 && ray.dir_y == '0 && ray.dir_z == '0, "degenerate ray with nonzero direction")
	`CPRD_ASSERT_NOW(a_dir_range, ray_valid, ray.dir_x <= 16'sd16384 && ray.dir_x >= -16'sd16384 && ray.dir_y <= 16'sd16384 && ray.dir_y >= -16'sd16384 && ray.dir_z <= 16'sd16384 && ray.dir_z >= -16'sd16384, "direction component beyond unit range")
	`CPRD_ASSERT_NOW(a_unit_nonzero, ray_valid && !ray.degenerate, ray.dir_x != '0 || ray.dir_y != '0 || ray.dir_z != '0, "normal ray with zero direction")
	`CPRD_ASSERT_NEXT(a_full_holds, fifo_cnt_q == 2'd2 && !pop, !pixel_ready && ray_valid, "full output queue did not hold the pipeline")

endmodule

// File: hw/rtl/cprd_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on cprd_pkg
module cprd_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [cprd_pkg::RAD_W-1:0] radicand,
	input  cprd_pkg::norm_t            in_side,
	output logic                       out_valid,
	output logic [cprd_pkg::ROOT_W-1:0] root,
	output cprd_pkg::norm_t            out_side
);
	import cprd_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	norm_t             side_s [ROOT_W];
	logic [ROOT_W-1:0] vld_s;

	logic [REM_W-1:0]  nrem  [ROOT_W];
	logic [ROOT_W-1:0] nroot [ROOT_W];
	logic [RAD_W-1:0]  nrad  [ROOT_W];

	always_comb begin
		logic [REM_W-1:0]  cur_rem;
		logic [ROOT_W-1:0] cur_root;
		logic [RAD_W-1:0]  cur_rad;
		logic [REM_W-1:0]  acc;
		logic [REM_W-1:0]  trial;
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				cur_rem  = '0;
				cur_root = '0;
				cur_rad  = radicand;
			end else begin
				cur_rem  = rem_s[k-1];
				cur_root = root_s[k-1];
				cur_rad  = rad_s[k-1];
			end
			acc   = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1 -: 2]};
			trial = {cur_root, 2'b01};
			if (acc >= trial) begin
				nrem[k]  = acc - trial;
				nroot[k] = {cur_root[ROOT_W-2:0], 1'b1};
			end else begin
				nrem[k]  = acc;
				nroot[k] = {cur_root[ROOT_W-2:0], 1'b0};
			end
			nrad[k] = {cur_rad[RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ROOT_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_W; k++) begin
				rem_s[k]  <= nrem[k];
				root_s[k] <= nroot[k];
				rad_s[k]  <= nrad[k];
				side_s[k] <= (k == 0) ? in_side : side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

// File: hw/rtl/cprd_div.sv
// pipelined rounded division of three magnitudes by the vector length
// one quotient bit per stage; depends on cprd_pkg
module cprd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [cprd_pkg::ROOT_W-1:0] len,
	input  cprd_pkg::norm_t             in_side,
	output logic                        out_valid,
	output cprd_pkg::quot_t             quot
);
	import cprd_pkg::*;

	localparam int CMP_W = NUM_W + 1;

	logic [2:0][NUM_W-1:0] rem_s [Q_W];
	logic [2:0][Q_W-1:0]   q_s   [Q_W];
	logic [ROOT_W-1:0]     len_s [Q_W];
	logic [2:0]            neg_s [Q_W];
	logic [Q_W-1:0]        dgn_s;
	logic [Q_W-1:0]        vld_s;

	logic [2:0][NUM_W-1:0] nrem [Q_W];
	logic [2:0][Q_W-1:0]   nq   [Q_W];

	always_comb begin
		logic [NUM_W-1:0]  cur_rem;
		logic [Q_W-1:0]    cur_q;
		logic [ROOT_W-1:0] cur_len;
		logic [CMP_W-1:0]  dvs;
		for (int k = 0; k < Q_W; k++) begin
			for (int i = 0; i < 3; i++) begin
				if (k == 0) begin
					// numerator with half the divisor added for rounding
					cur_rem = NUM_W'({in_side.mag[i], {FRAC_W{1'b0}}})
						+ NUM_W'(len >> 1);
					cur_q   = '0;
					cur_len = len;
				end else begin
					cur_rem = rem_s[k-1][i];
					cur_q   = q_s[k-1][i];
					cur_len = len_s[k-1];
				end
				dvs = CMP_W'(cur_len) << (Q_W - 1 - k);
				if ({1'b0, cur_rem} >= dvs) begin
					nrem[k][i] = cur_rem - dvs[NUM_W-1:0];
					nq[k][i]   = cur_q | (Q_W'(1) << (Q_W - 1 - k));
				end else begin
					nrem[k][i] = cur_rem;
					nq[k][i]   = cur_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[Q_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k] <= nrem[k];
				q_s[k]   <= nq[k];
				len_s[k] <= (k == 0) ? len : len_s[k-1];
				neg_s[k] <= (k == 0) ? in_side.neg : neg_s[k-1];
			end
			dgn_s <= {dgn_s[Q_W-2:0], in_side.degen};
		end
	end

	assign out_valid  = vld_s[Q_W-1];
	assign quot.q     = q_s[Q_W-1];
	assign quot.neg   = neg_s[Q_W-1];
	assign quot.degen = dgn_s[Q_W-1];

endmodule
